[rtl/core/obr_pkg.sv]
// Shared types and constants for the OHLCV bar resampler.
package obr_pkg;

   localparam int TIME_W   = 63;
   localparam int PRICE_W  = 48;
   localparam int VOL_IN_W = 48;
   localparam int VOL_W    = 53;
   localparam int GROUP_W  = 7;

   localparam logic [GROUP_W-1:0] GROUP_RESET = GROUP_W'(5);
   localparam logic [VOL_W-1:0]   VOL_MAX     = {VOL_W{1'b1}};

   // Work carried from the front to the back.
   typedef enum logic {
      OP_ACCUM = 1'b0,   // live candle, merge into the open bar
      OP_FLUSH = 1'b1    // tombstone on the last candle, close any open bar
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic                      last;
      logic [TIME_W-1:0]         time_stamp;
      logic signed [PRICE_W-1:0] open_p;
      logic signed [PRICE_W-1:0] high_p;
      logic signed [PRICE_W-1:0] low_p;
      logic signed [PRICE_W-1:0] close_p;
      logic [VOL_IN_W-2:0]       volume;   // sign bit dropped, known non-negative
   } entry_type;

   typedef struct packed {
      logic [TIME_W-1:0]         bar_time;
      logic signed [PRICE_W-1:0] bar_open;
      logic signed [PRICE_W-1:0] bar_high;
      logic signed [PRICE_W-1:0] bar_low;
      logic signed [PRICE_W-1:0] bar_close;
      logic [VOL_W-1:0]          bar_volume;
   } bar_type;

endpackage

[rtl/core/obr_front.sv]
// Front end: classifies each accepted candle into a queue entry.
module obr_front import obr_pkg::*; (
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [TIME_W-1:0]         req_candle_time,
   input  logic signed [PRICE_W-1:0] req_open_price,
   input  logic signed [PRICE_W-1:0] req_high_price,
   input  logic signed [PRICE_W-1:0] req_low_price,
   input  logic signed [PRICE_W-1:0] req_close_price,
   input  logic signed [VOL_IN_W-1:0] req_traded_volume,
   input  logic                      req_end_of_data,
   input  logic                      q_ready,
   output logic                      q_push,
   output entry_type                 q_entry
);

   logic tombstone;

   assign tombstone = req_traded_volume[VOL_IN_W-1];
   assign req_ready = q_ready;

   // A tombstone that is not the last candle changes nothing and is dropped here.
   assign q_push = req_valid && q_ready && (!tombstone || req_end_of_data);

   always_comb begin
      q_entry.op         = tombstone ? OP_FLUSH : OP_ACCUM;
      q_entry.last       = req_end_of_data;
      q_entry.time_stamp = req_candle_time;
      q_entry.open_p     = req_open_price;
      q_entry.high_p     = req_high_price;
      q_entry.low_p      = req_low_price;
      q_entry.close_p    = req_close_price;
      q_entry.volume     = req_traded_volume[VOL_IN_W-2:0];
   end

endmodule

[rtl/core/obr_queue.sv]
// Two-entry queue that decouples the front end from the bar accumulator.
module obr_queue import obr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   output logic      push_ready,
   input  entry_type push_entry,
   output logic      pop_valid,
   input  logic      pop,
   output entry_type pop_entry
);

   logic [1:0] count_ff, count_in;
   entry_type  head_ff, head_in;
   entry_type  spare_ff, spare_in;
   logic       do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_entry  = head_ff;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      spare_in = spare_ff;
      case ({push, do_pop})
         2'b10: begin
            count_in = count_ff + 2'd1;
            if (count_ff == 2'd0) begin
               head_in = push_entry;
            end else begin
               spare_in = push_entry;
            end
         end
         2'b01: begin
            count_in = count_ff - 2'd1;
            head_in  = spare_ff;
         end
         2'b11: begin
            // Only reachable with one entry held, so the new one becomes the head.
            head_in = push_entry;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff  <= head_in;
      spare_ff <= spare_in;
   end

endmodule

[rtl/core/obr_back.sv]
// Back end: merges candles into the open bar and holds the finished bar for output.
module obr_back import obr_pkg::*; #(
   parameter int MAX_GROUP = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [GROUP_W-1:0] csr_wr_data,
   input  logic               q_valid,
   output logic               q_pop,
   input  entry_type          q_entry,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bar_type            rsp_bar
);

   localparam int CNT_W = $clog2(MAX_GROUP + 1);
   localparam int GW    = (CNT_W > GROUP_W) ? CNT_W : GROUP_W;

   logic [GROUP_W-1:0]        group_size_ff;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [TIME_W-1:0]         time_ff, time_in;
   logic signed [PRICE_W-1:0] open_ff, open_in;
   logic signed [PRICE_W-1:0] high_ff, high_in;
   logic signed [PRICE_W-1:0] low_ff, low_in;
   logic signed [PRICE_W-1:0] close_ff, close_in;
   logic [VOL_W-1:0]          vol_ff, vol_in;
   logic                      out_valid_ff, out_valid_in;
   bar_type                   out_bar_ff, out_bar_in;

   logic [GW-1:0]    group_ext;
   logic [GW-1:0]    group_eff;
   logic [CNT_W-1:0] count_next;
   logic [VOL_W:0]   vol_sum;
   logic             first;
   logic             emit;

   assign q_pop     = q_valid && (!out_valid_ff || rsp_ready);
   assign rsp_valid = out_valid_ff;
   assign rsp_bar   = out_bar_ff;

   // Zero acts as one, anything above the maximum acts as the maximum.
   always_comb begin
      group_ext = GW'(group_size_ff);
      if (group_ext == '0) begin
         group_eff = GW'(1);
      end else if (group_ext > GW'(MAX_GROUP)) begin
         group_eff = GW'(MAX_GROUP);
      end else begin
         group_eff = group_ext;
      end
   end

   always_comb begin
      first      = (count_ff == '0);
      count_next = count_ff + CNT_W'(1);
      vol_sum    = (first ? (VOL_W+1)'(0) : (VOL_W+1)'(vol_ff))
                   + (VOL_W+1)'(q_entry.volume);

      count_in     = count_ff;
      time_in      = time_ff;
      open_in      = open_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      close_in     = close_ff;
      vol_in       = vol_ff;
      emit         = 1'b0;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_bar_in   = out_bar_ff;

      if (q_pop) begin
         case (q_entry.op)
            OP_ACCUM: begin
               count_in = count_next;
               if (first) begin
                  time_in = q_entry.time_stamp;
                  open_in = q_entry.open_p;
                  high_in = q_entry.high_p;
                  low_in  = q_entry.low_p;
               end else begin
                  if (q_entry.high_p > high_ff) begin
                     high_in = q_entry.high_p;
                  end
                  if (q_entry.low_p < low_ff) begin
                     low_in = q_entry.low_p;
                  end
               end
               close_in = q_entry.close_p;
               vol_in   = vol_sum[VOL_W] ? VOL_MAX : vol_sum[VOL_W-1:0];
               emit     = (GW'(count_next) >= group_eff) || q_entry.last;
            end
            OP_FLUSH: begin
               emit = !first;
            end
            default: begin
            end
         endcase
      end

      if (emit) begin
         out_valid_in          = 1'b1;
         out_bar_in.bar_time   = time_in;
         out_bar_in.bar_open   = open_in;
         out_bar_in.bar_high   = high_in;
         out_bar_in.bar_low    = low_in;
         out_bar_in.bar_close  = close_in;
         out_bar_in.bar_volume = vol_in;
         count_in              = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= GROUP_RESET;
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            group_size_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      time_ff    <= time_in;
      open_ff    <= open_in;
      high_ff    <= high_in;
      low_ff     <= low_in;
      close_ff   <= close_in;
      vol_ff     <= vol_in;
      out_bar_ff <= out_bar_in;
   end

endmodule

[rtl/core/ohlcv_bar_resampler.sv]
// Top level of the OHLCV bar resampler: front end, queue and bar accumulator.
//
// Candles arrive on the req_ channel, one beat per candle, in ascending time order.
// Each run of group_size live candles becomes one bar on the rsp_ channel, one beat
// per bar. A candle with negative volume is a tombstone and is skipped; end_of_data
// closes any partial bar, also when it rides on a tombstone.
// The csr_ port writes group_size; write it only while idle.
// A value of zero acts as one, and a value above MAX_GROUP acts as MAX_GROUP.
// Throughput is one candle per cycle while the receiver keeps up. With the queue
// empty, the candle that closes a bar is first registered at the queue head; the
// accumulator then merges it and loads the finished bar into the output register,
// which drives rsp_valid.
// When the receiver stalls, the output register holds its bar, the accumulator
// stops popping, and the queue fills; req_ready drops once two candles wait.
// Reset is synchronous and empties the queue, drops any open bar and any bar
// waiting on the output, and sets group_size back to five.
module ohlcv_bar_resampler import obr_pkg::*; #(
   parameter int MAX_GROUP = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [GROUP_W-1:0]         csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [TIME_W-1:0]          req_candle_time,
   input  logic signed [PRICE_W-1:0]  req_open_price,
   input  logic signed [PRICE_W-1:0]  req_high_price,
   input  logic signed [PRICE_W-1:0]  req_low_price,
   input  logic signed [PRICE_W-1:0]  req_close_price,
   input  logic signed [VOL_IN_W-1:0] req_traded_volume,
   input  logic                       req_end_of_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [TIME_W-1:0]          rsp_bar_time,
   output logic signed [PRICE_W-1:0]  rsp_bar_open,
   output logic signed [PRICE_W-1:0]  rsp_bar_high,
   output logic signed [PRICE_W-1:0]  rsp_bar_low,
   output logic signed [PRICE_W-1:0]  rsp_bar_close,
   output logic [VOL_W-1:0]           rsp_bar_volume
);

   logic      q_ready;
   logic      q_push;
   entry_type q_in_entry;
   logic      q_valid;
   logic      q_pop;
   entry_type q_out_entry;
   bar_type   bar;

   // Classification: tombstones that do not end the stream never enter the queue.
   obr_front u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_candle_time   (req_candle_time),
      .req_open_price    (req_open_price),
      .req_high_price    (req_high_price),
      .req_low_price     (req_low_price),
      .req_close_price   (req_close_price),
      .req_traded_volume (req_traded_volume),
      .req_end_of_data   (req_end_of_data),
      .q_ready           (q_ready),
      .q_push            (q_push),
      .q_entry           (q_in_entry)
   );

   // The queue lets the front keep accepting while the back waits on the receiver.
   obr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_ready (q_ready),
      .push_entry (q_in_entry),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_entry  (q_out_entry)
   );

   // The accumulator keeps the open bar and the output register.
   obr_back #(
      .MAX_GROUP (MAX_GROUP)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_entry     (q_out_entry),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_bar     (bar)
   );

   assign rsp_bar_time   = bar.bar_time;
   assign rsp_bar_open   = bar.bar_open;
   assign rsp_bar_high   = bar.bar_high;
   assign rsp_bar_low    = bar.bar_low;
   assign rsp_bar_close  = bar.bar_close;
   assign rsp_bar_volume = bar.bar_volume;

endmodule
